// ----- rtl/core/cth_pkg.sv -----
package cth_pkg;

    localparam int NUM_PADDLES = 16;
    localparam int NUM_BINS    = 200;
    localparam int COUNT_BITS  = 32;
    localparam int NUM_HISTS   = 4;
    localparam int HIST_LEN    = NUM_BINS + 2;
    localparam int PAD_BITS    = $clog2(NUM_PADDLES);
    localparam int BIN_BITS    = $clog2(HIST_LEN);
    localparam int MEM_DEPTH   = NUM_HISTS * HIST_LEN;
    localparam int ADDR_BITS   = $clog2(MEM_DEPTH);
    localparam int TIME_BITS   = 35;
    localparam int QUO_BITS    = 35;

    localparam logic [2:0] REG_A1_THR  = 3'd0;
    localparam logic [2:0] REG_A2_THR  = 3'd1;
    localparam logic [2:0] REG_OFFSET  = 3'd2;
    localparam logic [2:0] REG_LOW     = 3'd3;
    localparam logic [2:0] REG_WIDTH   = 3'd4;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_END   = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PAIR,
        ST_DIV,
        ST_BUMP_RD,
        ST_BUMP_WR,
        ST_READ_RD,
        ST_READ_OUT,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic load_hit;
        logic start_event;
        logic start_pair;
        logic div_start;
        logic div_step;
        logic next_cut;
        logic mem_rd_bump;
        logic mem_wr_bump;
        logic mem_rd_req;
        logic out_load;
        logic clear_step;
        logic clear_start;
        logic end_clear;
    } cmd_t;

    typedef struct packed {
        logic pair_good;
        logic pair_last;
        logic div_done;
        logic cut_last;
        logic cut_valid;
        logic clear_last;
    } status_t;

endpackage

// ----- rtl/core/coincidence_time_histogrammer.sv -----
// Read request: the count is read into a register and then into the output register,
// which raises m_valid; input waits while the count is unaccepted.
// Clear request: zeroes the count memory, one entry per cycle.
// End event: steps through all 256 paddle pairs; each good pair runs the serial divider
// and six cut slots, with a read and a write of the count memory for each cut that passes.
// Reset (aresetn, synchronous, active low) loads register defaults and then sweeps
// the 808-entry count memory, one entry per cycle, before input is accepted.
module coincidence_time_histogrammer
    import cth_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic               s_arm,
    input  logic [3:0]         s_paddle,
    input  logic signed [31:0] s_hit_time_ps,
    input  logic               s_left_fired,
    input  logic               s_right_fired,
    input  logic signed [16:0] s_a1_sum,
    input  logic signed [16:0] s_a2_sum,
    input  logic [1:0]         s_hist_select,
    input  logic [7:0]         s_bin_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_bin_count
);

    cmd_t    cmd;
    status_t sts;

    assign cfg_ready = 1'b1;

    cth_control u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_action, .s_paddle,
        .m_valid, .m_ready, .cmd, .sts
    );

    cth_datapath u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .cfg_valid, .cfg_index, .cfg_data,
        .s_arm, .s_paddle, .s_hit_time_ps, .s_left_fired, .s_right_fired,
        .s_a1_sum, .s_a2_sum, .s_hist_select, .s_bin_index, .m_bin_count
    );

endmodule

// ----- rtl/core/cth_datapath.sv -----
module cth_datapath
    import cth_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output status_t               sts,
    input  logic                  cfg_valid,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  s_arm,
    input  logic [3:0]            s_paddle,
    input  logic signed [31:0]    s_hit_time_ps,
    input  logic                  s_left_fired,
    input  logic                  s_right_fired,
    input  logic signed [16:0]    s_a1_sum,
    input  logic signed [16:0]    s_a2_sum,
    input  logic [1:0]            s_hist_select,
    input  logic [7:0]            s_bin_index,
    output logic [31:0]           m_bin_count
);

    logic signed [16:0] a1_thr_reg, a2_thr_reg;
    logic signed [20:0] offset_reg, low_reg;
    logic [16:0]        width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a1_thr_reg <= 17'sd130;
            a2_thr_reg <= 17'sd3000;
            offset_reg <= 21'sd150700;
            low_reg    <= -21'sd25000;
            width_reg  <= 17'd200;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_A1_THR: a1_thr_reg <= cfg_data[16:0];
                REG_A2_THR: a2_thr_reg <= cfg_data[16:0];
                REG_OFFSET: offset_reg <= cfg_data[20:0];
                REG_LOW:    low_reg    <= cfg_data[20:0];
                REG_WIDTH:  width_reg  <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    logic signed [31:0] right_times [NUM_PADDLES];
    logic signed [31:0] left_times  [NUM_PADDLES];
    logic [NUM_PADDLES-1:0] right_good_reg, left_good_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_hit) begin
            if (!s_arm) right_times[s_paddle[PAD_BITS-1:0]] <= s_hit_time_ps;
            else        left_times[s_paddle[PAD_BITS-1:0]]  <= s_hit_time_ps;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            right_good_reg <= '0;
            left_good_reg  <= '0;
        end else if (cmd.load_hit) begin
            if (!s_arm) right_good_reg[s_paddle[PAD_BITS-1:0]] <= s_left_fired & s_right_fired;
            else        left_good_reg[s_paddle[PAD_BITS-1:0]]  <= s_left_fired & s_right_fired;
        end else if (cmd.end_clear) begin
            right_good_reg <= '0;
            left_good_reg  <= '0;
        end
    end

    logic a1pass_reg, a2pass_reg;
    logic [2*PAD_BITS-1:0] pair_reg;
    always_ff @(posedge aclk) begin
        if (cmd.start_event) begin
            a1pass_reg <= !(s_a1_sum > a1_thr_reg);
            a2pass_reg <= s_a2_sum > a2_thr_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.start_event)     pair_reg <= '0;
        else if (cmd.start_pair) pair_reg <= pair_reg + 1'b1;
    end
    wire [PAD_BITS-1:0] rk = pair_reg[2*PAD_BITS-1:PAD_BITS];
    wire [PAD_BITS-1:0] lj = pair_reg[PAD_BITS-1:0];
    assign sts.pair_good = right_good_reg[rk] & left_good_reg[lj];
    assign sts.pair_last = &pair_reg;

    // bin search: restoring divide, one quotient bit per cycle
    logic signed [TIME_BITS-1:0] diff;
    logic [QUO_BITS-1:0] num_reg, quo_reg;
    logic [17:0] rem_reg;
    logic [5:0]  step_reg;
    logic        under_reg;
    wire  [16:0] wd = (width_reg == '0) ? 17'd1 : width_reg;
    assign diff = TIME_BITS'(right_times[rk]) - TIME_BITS'(left_times[lj])
                + TIME_BITS'(offset_reg) - TIME_BITS'(low_reg);
    logic [17:0] rem_sh;
    assign rem_sh = {rem_reg[16:0], num_reg[QUO_BITS-1]};

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            under_reg <= diff[TIME_BITS-1];
            num_reg   <= diff;
            quo_reg   <= '0;
            rem_reg   <= '0;
            step_reg  <= '0;
        end else if (cmd.div_step) begin
            num_reg  <= num_reg << 1;
            step_reg <= step_reg + 1'b1;
            if (rem_sh >= {1'b0, wd}) begin
                rem_reg <= rem_sh - {1'b0, wd};
                quo_reg <= {quo_reg[QUO_BITS-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[QUO_BITS-2:0], 1'b0};
            end
        end
    end
    assign sts.div_done = (step_reg == 6'(QUO_BITS));

    logic [BIN_BITS-1:0] bin;
    always_comb begin
        if (under_reg)                      bin = '0;
        else if (quo_reg >= QUO_BITS'(NUM_BINS)) bin = BIN_BITS'(NUM_BINS + 1);
        else                                bin = BIN_BITS'(quo_reg) + 1'b1;
    end

    // cut sequence: 0 a1, 1 a2, 2 both; each bumps its hist and the all hist
    logic [2:0] cut_reg;
    logic       cut_valid;
    always_ff @(posedge aclk) begin
        if (cmd.div_start)     cut_reg <= 3'd0;
        else if (cmd.next_cut) cut_reg <= cut_reg + 1'b1;
    end
    assign sts.cut_last = (cut_reg == 3'd5);
    wire [1:0] cut_id = cut_reg[2:1];
    always_comb begin
        case (cut_id)
            2'd0:    cut_valid = a1pass_reg;
            2'd1:    cut_valid = a2pass_reg;
            default: cut_valid = a1pass_reg & a2pass_reg;
        endcase
    end
    assign sts.cut_valid = cut_valid;
    wire [1:0] cut_hist = cut_reg[0] ? (cut_id + 2'd1) : 2'd0;

    logic [COUNT_BITS-1:0] mem [MEM_DEPTH];
    logic [COUNT_BITS-1:0] rd_reg;
    logic [ADDR_BITS-1:0]  clr_reg;
    logic [ADDR_BITS-1:0]  addr;
    always_comb begin
        if (cmd.mem_rd_req)
            addr = ADDR_BITS'(s_hist_select * HIST_LEN) + ADDR_BITS'(s_bin_index);
        else
            addr = ADDR_BITS'(cut_hist * HIST_LEN) + ADDR_BITS'(bin);
    end
    logic [ADDR_BITS-1:0] waddr_reg;
    always_ff @(posedge aclk) begin
        if (cmd.clear_step)
            mem[clr_reg] <= '0;
        else if (cmd.mem_wr_bump)
            mem[waddr_reg] <= (&rd_reg) ? rd_reg : rd_reg + 1'b1;
        if (cmd.mem_rd_bump || cmd.mem_rd_req) begin
            rd_reg    <= mem[addr];
            waddr_reg <= addr;
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_start) clr_reg <= '0;
        else if (cmd.clear_step)         clr_reg <= clr_reg + 1'b1;
    end
    assign sts.clear_last = (clr_reg == ADDR_BITS'(MEM_DEPTH - 1));

    logic oor_reg;
    always_ff @(posedge aclk) begin
        if (cmd.mem_rd_req) oor_reg <= (s_bin_index >= 8'(HIST_LEN));
        if (cmd.out_load)   m_bin_count <= oor_reg ? '0 : rd_reg;
    end

endmodule

// ----- rtl/core/cth_control.sv -----
module cth_control
    import cth_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [3:0]  s_paddle,
    output logic        m_valid,
    input  logic        m_ready,
    output cmd_t        cmd,
    input  status_t     sts
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_ready = !(m_valid_reg && !m_ready);
                if (s_valid && s_ready) begin
                    unique case (s_action)
                        ACT_LOAD: cmd.load_hit = ({1'b0, s_paddle} < 5'(NUM_PADDLES));
                        ACT_END: begin
                            cmd.start_event = 1'b1;
                            state_next = ST_PAIR;
                        end
                        ACT_READ: begin
                            cmd.mem_rd_req = 1'b1;
                            state_next = ST_READ_OUT;
                        end
                        default: begin
                            cmd.clear_start = 1'b1;
                            state_next = ST_CLEAR;
                        end
                    endcase
                end
            end
            ST_PAIR: begin
                if (sts.pair_good) begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    cmd.start_pair = 1'b1;
                    if (sts.pair_last) begin
                        cmd.end_clear = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV: begin
                if (sts.div_done) state_next = ST_BUMP_RD;
                else cmd.div_step = 1'b1;
            end
            ST_BUMP_RD: begin
                if (sts.cut_valid) begin
                    cmd.mem_rd_bump = 1'b1;
                    state_next = ST_BUMP_WR;
                end else if (sts.cut_last) begin
                    cmd.start_pair = 1'b1;
                    if (sts.pair_last) begin
                        cmd.end_clear = 1'b1;
                        state_next = ST_IDLE;
                    end else state_next = ST_PAIR;
                end else cmd.next_cut = 1'b1;
            end
            ST_BUMP_WR: begin
                cmd.mem_wr_bump = 1'b1;
                if (sts.cut_last) begin
                    cmd.start_pair = 1'b1;
                    if (sts.pair_last) begin
                        cmd.end_clear = 1'b1;
                        state_next = ST_IDLE;
                    end else state_next = ST_PAIR;
                end else begin
                    cmd.next_cut = 1'b1;
                    state_next = ST_BUMP_RD;
                end
            end
            ST_READ_OUT: begin
                cmd.out_load = 1'b1;
                m_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
